[hdl/yuvc_pkg.sv]
// ----------------------------------------------------------------------------
// yuvc_pkg
// Shared types and constants for the YUV/BGRA to RGBA pixel converter.
// ----------------------------------------------------------------------------
package yuvc_pkg;

   // Source format codes held in the format register.
   typedef enum logic [1:0] {
      FMT_PLANAR = 2'd0,
      FMT_PACKED = 2'd1,
      FMT_SWAP   = 2'd2
   } fmt_type;

   localparam fmt_type FMT_RESET = FMT_SWAP;

   // BT.601 integer coefficients and offsets.
   localparam int COEF_Y     = 298;
   localparam int COEF_RV    = 409;
   localparam int COEF_GU    = 100;
   localparam int COEF_GV    = 208;
   localparam int COEF_BU    = 516;
   localparam int ROUND_BIAS = 128;
   localparam int LUMA_OFS   = 16;
   localparam int CHROMA_OFS = 128;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Width of the signed accumulation before the shift by 8.
   localparam int SUM_W = 19;

   // One RGBA pixel; red sits in the lowest bits when packed.
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // Input item held in the input register.
   typedef struct packed {
      logic       lone_pixel;
      logic [7:0] byte_d;
      logic [7:0] byte_c;
      logic [7:0] byte_b;
      logic [7:0] byte_a;
   } item_type;

endpackage

[hdl/yuvc_color_convert.sv]
// ----------------------------------------------------------------------------
// yuvc_color_convert
// Combinational BT.601 conversion of one Y, U, V triple to clamped RGB.
// ----------------------------------------------------------------------------
module yuvc_color_convert
   import yuvc_pkg::*;
(
   input  logic [7:0] luma,
   input  logic [7:0] chroma_u,
   input  logic [7:0] chroma_v,
   output pixel_type  pixel
);

   logic signed [SUM_W-1:0] c_ext;
   logic signed [SUM_W-1:0] d_ext;
   logic signed [SUM_W-1:0] e_ext;
   logic signed [SUM_W-1:0] y_term;
   logic signed [SUM_W-1:0] red_sum;
   logic signed [SUM_W-1:0] green_sum;
   logic signed [SUM_W-1:0] blue_sum;

   // Clamp floor(sum / 256) to 0..255: negative gives 0, above 255 gives 255.
   function automatic logic [7:0] clamp_shift(input logic signed [SUM_W-1:0] sum);
      logic [7:0] result;
      if (sum[SUM_W-1]) begin
         result = 8'd0;
      end else if (|sum[SUM_W-2:16]) begin
         result = 8'hFF;
      end else begin
         result = sum[15:8];
      end
      return result;
   endfunction

   // Remove the luma and chroma offsets.
   assign c_ext = $signed({{(SUM_W-8){1'b0}}, luma})     - SUM_W'(LUMA_OFS);
   assign d_ext = $signed({{(SUM_W-8){1'b0}}, chroma_u}) - SUM_W'(CHROMA_OFS);
   assign e_ext = $signed({{(SUM_W-8){1'b0}}, chroma_v}) - SUM_W'(CHROMA_OFS);

   // Constant products and rounded sums for each channel.
   assign y_term    = c_ext * SUM_W'(COEF_Y);
   assign red_sum   = y_term + e_ext * SUM_W'(COEF_RV) + SUM_W'(ROUND_BIAS);
   assign green_sum = y_term - d_ext * SUM_W'(COEF_GU) - e_ext * SUM_W'(COEF_GV)
                      + SUM_W'(ROUND_BIAS);
   assign blue_sum  = y_term + d_ext * SUM_W'(COEF_BU) + SUM_W'(ROUND_BIAS);

   // Clamp and pack; alpha is opaque for YUV sources.
   always_comb begin
      pixel.red   = clamp_shift(red_sum);
      pixel.green = clamp_shift(green_sum);
      pixel.blue  = clamp_shift(blue_sum);
      pixel.alpha = ALPHA_OPAQUE;
   end

endmodule

[hdl/yuv_bgra_to_rgba_pixel_converter_core.sv]
// ----------------------------------------------------------------------------
// yuv_bgra_to_rgba_pixel_converter_core
// Converts planar 4:2:0, packed 4:2:2 or BGRA items to RGBA pixels.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req_*    in         tdata: byte_a, byte_b, byte_c, byte_d; tuser: lone_pixel
//  rsp_*    out        tdata: red, green, blue, alpha; tlast: last
//  csr_*    in         csr_data: source_format
//
// An item is taken into the input register and, unless the result stalls, one
// pixel per cycle goes from there through the converter into the result
// register. Planar, swap and lone packed items give one pixel each; full packed
// items give two pixels, one after the other, from the single converter. Reset
// empties both registers and sets the format to swap. A stalled result holds
// the result register and, behind it, the item.
// ----------------------------------------------------------------------------
module yuv_bgra_to_rgba_pixel_converter_core
   import yuvc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // byte_a, byte_b, byte_c, byte_d
   input  logic        req_tuser,   // lone_pixel
   // Result pixels.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // red, green, blue, alpha
   output logic        rsp_tlast,
   // Format register write.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data     // source_format
);

   fmt_type    fmt_ff, fmt_in;
   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;
   logic       half_ff, half_in;
   logic       out_valid_ff, out_valid_in;
   pixel_type  out_pixel_ff, out_pixel_in;
   logic       out_last_ff, out_last_in;

   logic       req_accept;
   logic       out_free;
   logic       emit;
   logic       is_final;
   logic       two_pixels;
   logic [7:0] sel_y;
   logic [7:0] sel_v;
   pixel_type  yuv_pixel;
   pixel_type  next_pixel;

   // Format register; writes are always taken.
   assign csr_ready = 1'b1;
   assign fmt_in    = (csr_valid && csr_ready) ? fmt_type'(csr_data) : fmt_ff;

   // Handshake and advance control.
   assign two_pixels = (fmt_ff == FMT_PACKED) && !item_ff.lone_pixel;
   assign is_final   = !two_pixels || half_ff;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign emit       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || (emit && is_final);
   assign req_accept = req_tvalid && req_tready;

   // Input register and pixel index.
   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff;
      half_in     = half_ff;
      if (req_accept) begin
         item_in     = item_type'({req_tuser, req_tdata});
         in_valid_in = 1'b1;
         half_in     = 1'b0;
      end else if (emit && is_final) begin
         in_valid_in = 1'b0;
      end else if (emit) begin
         half_in = 1'b1;
      end
   end

   // Luma and chroma selection for the current pixel.
   always_comb begin
      sel_y = half_ff ? item_ff.byte_c : item_ff.byte_a;
      sel_v = (fmt_ff == FMT_PLANAR) ? item_ff.byte_c : item_ff.byte_d;
   end

   yuvc_color_convert u_convert (
      .luma     (sel_y),
      .chroma_u (item_ff.byte_b),
      .chroma_v (sel_v),
      .pixel    (yuv_pixel)
   );

   // Pick the YUV result or the byte reorder.
   always_comb begin
      case (fmt_ff)
         FMT_PLANAR, FMT_PACKED: begin
            next_pixel = yuv_pixel;
         end
         default: begin
            next_pixel.red   = item_ff.byte_c;
            next_pixel.green = item_ff.byte_b;
            next_pixel.blue  = item_ff.byte_a;
            next_pixel.alpha = item_ff.byte_d;
         end
      endcase
   end

   // Result register.
   always_comb begin
      out_pixel_in = out_pixel_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (emit) begin
         out_pixel_in = next_pixel;
         out_last_in  = is_final;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= FMT_RESET;
         in_valid_ff  <= 1'b0;
         half_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         in_valid_ff  <= in_valid_in;
         half_ff      <= half_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      out_pixel_ff <= out_pixel_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tlast  = out_last_ff;

   // The second pixel index is only used by a full packed item.
   a_half_only_packed: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && half_ff) |-> two_pixels)
      else $error("second pixel index outside a full packed item");

   // A first packed pixel leaves the item in place for its second pixel.
   a_first_keeps_item: assert property (@(posedge clock) disable iff (reset)
      (emit && !is_final) |=> (in_valid_ff && half_ff))
      else $error("packed item lost after its first pixel");

   // An item is only taken when the result register can drain the current one.
   a_accept_needs_room: assert property (@(posedge clock) disable iff (reset)
      (req_accept && in_valid_ff) |-> (out_free && is_final))
      else $error("item accepted over an unfinished item");

endmodule
